FILE: src/psgeg_pkg.sv
`default_nettype none

package psgeg_pkg;

	// Field and register widths.
	localparam int unsigned LEVEL_W  = 8;
	localparam int unsigned PHASE_W  = 2;
	localparam int unsigned SHAPE_W  = 5;
	localparam int unsigned PERIOD_W = 16;
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned ADDR_W   = 3;

	// Register indexes (word address bit two).
	localparam logic REG_SHAPE  = 1'b0;
	localparam logic REG_PERIOD = 1'b1;

	typedef logic [LEVEL_W-1:0]  level_t;
	typedef logic [PHASE_W-1:0]  phase_t;
	typedef logic [SHAPE_W-1:0]  shape_t;
	typedef logic [PERIOD_W-1:0] period_t;

	// Ramp phase codes as seen on the result channel.
	localparam phase_t PH_FALL = 2'd0;
	localparam phase_t PH_RISE = 2'd1;
	localparam phase_t PH_HOLD = 2'd2;

	localparam level_t LEVEL_TOP = 8'd255;
	localparam level_t LEVEL_BOT = 8'd0;

	// Register write commands from the bus decoder to the envelope core.
	typedef struct packed {
		logic    shape_we;
		logic    period_we;
		period_t wdata;
	} cfg_wr_t;

	// Register and envelope state shown by the core.
	typedef struct packed {
		shape_t  shape;
		period_t period;
		level_t  level;
		phase_t  phase;
	} env_stat_t;

endpackage

`default_nettype wire

FILE: src/psg_envelope_generator_top.sv
// Envelope generator of a programmable sound chip, 8-bit amplitude.
// Input channel (in_valid, in_stall, tick): one transaction per audio sample.
// Each accepted transaction yields exactly one result transaction
// (out_valid, out_stall, env_level, env_phase) holding the level and phase
// as they were before that transaction's step; a tick of zero reports
// without advancing.
// Registered result: with the output free, it is in the output register on
// the cycle after acceptance. Throughput is one transaction per clock while
// in_stall is low, set by the prescaler compare and level update in the core.
// When the receiver stalls, the output register holds its result and a
// skid register takes one more; in_stall rises only while the skid
// register is full.
// The APB port writes env_shape at 0x0 and env_period at 0x4; writing the
// shape restarts the envelope. Write registers only while the block is idle.
// Reset sets shape 16 (disabled, holding at level 0), period 0 and
// empties both result registers.
`default_nettype none

module psg_envelope_generator_top (
	input  wire                                clk,
	input  wire                                arst_n,
	// APB configuration port
	input  wire                                psel,
	input  wire                                penable,
	input  wire                                pwrite,
	input  wire  [psgeg_pkg::ADDR_W-1:0]       paddr,
	input  wire  [psgeg_pkg::DATA_W-1:0]       pwdata,
	output logic [psgeg_pkg::DATA_W-1:0]       prdata,
	output logic                               pready,
	// Input channel
	input  wire                                in_valid,
	output logic                               in_stall,
	input  wire                                tick,
	// Result channel
	output logic                               out_valid,
	input  wire                                out_stall,
	output psgeg_pkg::level_t                  env_level,
	output psgeg_pkg::phase_t                  env_phase
);

	psgeg_pkg::cfg_wr_t   cfg_wr;
	psgeg_pkg::env_stat_t stat;

	logic               wr_en;
	logic               in_acc;
	logic               out_free;
	logic               skid_v_q;
	psgeg_pkg::level_t  skid_level_q;
	psgeg_pkg::phase_t  skid_phase_q;

	// Register write decode; byte lane bits are ignored.
	assign pready           = 1'b1;
	assign wr_en            = psel && penable && pwrite;
	assign cfg_wr.shape_we  = wr_en && (paddr[2] == psgeg_pkg::REG_SHAPE);
	assign cfg_wr.period_we = wr_en && (paddr[2] == psgeg_pkg::REG_PERIOD);
	assign cfg_wr.wdata     = pwdata[psgeg_pkg::PERIOD_W-1:0];

	// Register read back.
	always_comb begin
		prdata = '0;
		case (paddr[2])
			psgeg_pkg::REG_SHAPE:  prdata[psgeg_pkg::SHAPE_W-1:0]  = stat.shape;
			psgeg_pkg::REG_PERIOD: prdata[psgeg_pkg::PERIOD_W-1:0] = stat.period;
			default:               prdata = '0;
		endcase
	end

	assign in_stall = skid_v_q;
	assign in_acc   = in_valid && !skid_v_q;
	assign out_free = !out_valid || !out_stall;

	psgeg_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_wr  (cfg_wr),
		.step_en (in_acc && tick),
		.stat    (stat)
	);

	// Output register with one skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			skid_v_q  <= 1'b0;
		end else if (out_free) begin
			if (skid_v_q) begin
				out_valid <= 1'b1;
				skid_v_q  <= 1'b0;
			end else begin
				out_valid <= in_acc;
			end
		end else if (in_acc) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_v_q) begin
				env_level <= skid_level_q;
				env_phase <= skid_phase_q;
			end else if (in_acc) begin
				env_level <= stat.level;
				env_phase <= stat.phase;
			end
		end else if (in_acc) begin
			skid_level_q <= stat.level;
			skid_phase_q <= stat.phase;
		end
	end

endmodule

`default_nettype wire

FILE: src/psgeg_core.sv
`default_nettype none

module psgeg_core (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire psgeg_pkg::cfg_wr_t cfg_wr,
	input  wire                  step_en,
	output psgeg_pkg::env_stat_t stat
);

	psgeg_pkg::shape_t  shape_q;
	psgeg_pkg::period_t period_q;
	psgeg_pkg::period_t counter_q;
	psgeg_pkg::level_t  level_q;
	psgeg_pkg::phase_t  phase_q;

	logic [psgeg_pkg::PERIOD_W:0] next_cnt;
	logic                         step_due;
	logic                         ramping;
	psgeg_pkg::shape_t            wr_shape;

	assign wr_shape = cfg_wr.wdata[psgeg_pkg::SHAPE_W-1:0];
	assign ramping  = (phase_q == psgeg_pkg::PH_FALL) || (phase_q == psgeg_pkg::PH_RISE);
	assign next_cnt = {1'b0, counter_q} + {{psgeg_pkg::PERIOD_W{1'b0}}, 1'b1};
	assign step_due = next_cnt >= {1'b0, period_q};

	// Shape writes restart the envelope; ticks advance the prescaler and level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_q   <= psgeg_pkg::shape_t'(16);
			period_q  <= '0;
			counter_q <= '0;
			level_q   <= psgeg_pkg::LEVEL_BOT;
			phase_q   <= psgeg_pkg::PH_HOLD;
		end else if (cfg_wr.shape_we) begin
			counter_q <= '0;
			if (!wr_shape[4]) begin
				shape_q <= wr_shape;
				if (wr_shape[2]) begin
					level_q <= psgeg_pkg::LEVEL_BOT;
					phase_q <= psgeg_pkg::PH_RISE;
				end else begin
					level_q <= psgeg_pkg::LEVEL_TOP;
					phase_q <= psgeg_pkg::PH_FALL;
				end
			end else begin
				shape_q  <= '0;
				period_q <= '0;
				level_q  <= psgeg_pkg::LEVEL_BOT;
				phase_q  <= psgeg_pkg::PH_HOLD;
			end
		end else if (cfg_wr.period_we) begin
			period_q <= cfg_wr.wdata;
		end else if (step_en && ramping) begin
			if (!step_due) begin
				counter_q <= next_cnt[psgeg_pkg::PERIOD_W-1:0];
			end else begin
				counter_q <= '0;
				if (phase_q == psgeg_pkg::PH_FALL) begin
					if (level_q != psgeg_pkg::LEVEL_BOT) begin
						level_q <= level_q - 8'd1;
					end else begin
						// End of a falling ramp: the shape picks the next move.
						case (shape_q) inside
							[5'd0:5'd3], 5'd9: begin
								phase_q <= psgeg_pkg::PH_HOLD;
							end
							5'd8: begin
								level_q <= psgeg_pkg::LEVEL_TOP;
							end
							5'd10, 5'd14: begin
								phase_q <= psgeg_pkg::PH_RISE;
							end
							5'd11: begin
								level_q <= psgeg_pkg::LEVEL_TOP;
								phase_q <= psgeg_pkg::PH_HOLD;
							end
							default: begin
							end
						endcase
					end
				end else begin
					if (level_q != psgeg_pkg::LEVEL_TOP) begin
						level_q <= level_q + 8'd1;
					end else begin
						// End of a rising ramp: the shape picks the next move.
						case (shape_q) inside
							[5'd4:5'd7], 5'd15: begin
								level_q <= psgeg_pkg::LEVEL_BOT;
								phase_q <= psgeg_pkg::PH_HOLD;
							end
							5'd10, 5'd14: begin
								phase_q <= psgeg_pkg::PH_FALL;
							end
							5'd12: begin
								level_q <= psgeg_pkg::LEVEL_BOT;
							end
							5'd13: begin
								phase_q <= psgeg_pkg::PH_HOLD;
							end
							default: begin
							end
						endcase
					end
				end
			end
		end
	end

	assign stat.shape  = shape_q;
	assign stat.period = period_q;
	assign stat.level  = level_q;
	assign stat.phase  = phase_q;

endmodule

`default_nettype wire

FILE: src/psgeg_checker.sv
`default_nettype none

module psgeg_checker (
	input wire                    clk,
	input wire                    arst_n,
	input wire                    in_valid,
	input wire                    in_stall,
	input wire                    out_valid,
	input wire                    out_stall,
	input wire [7:0]              env_level,
	input wire [1:0]              env_phase
);

	// A stalled result transaction is not withdrawn.
	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result transaction dropped while stalled");

	// The skid entry can only be full while the output register is full.
	a_stall_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with an empty output register");

	// Only the falling, rising and holding phase codes appear.
	a_phase_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (env_phase == psgeg_pkg::PH_FALL) ||
			(env_phase == psgeg_pkg::PH_RISE) || (env_phase == psgeg_pkg::PH_HOLD))
		else $error("invalid phase code on result");

	// A holding envelope rests at one end of the range.
	a_hold_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (env_phase == psgeg_pkg::PH_HOLD) |->
			(env_level == psgeg_pkg::LEVEL_BOT) || (env_level == psgeg_pkg::LEVEL_TOP))
		else $error("holding level not at an end of the range");

	// An input accepted while the output is stalled leaves the skid entry full.
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && out_valid && out_stall |=> in_stall)
		else $error("transaction taken during stall did not fill the skid entry");

endmodule

bind psg_envelope_generator_top psgeg_checker u_psgeg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.env_level (env_level),
	.env_phase (env_phase)
);

`default_nettype wire
